// ----- sv/cma_pkg.sv -----
// cascaded moving average: shared types and constants
// controller states, command and status structs between controller and datapath
// no dependencies
`default_nettype none

package cma_pkg;

  localparam int SAMPLE_W          = 16;
  localparam int REPORT_W          = 2;
  localparam int WINDOW_POINTS_DEF = 8;
  localparam int LEVELS_DEF        = 4;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_SEED   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_SEED,
    ST_READ,
    ST_WRITE,
    ST_DIV,
    ST_DIV_WAIT,
    ST_FIN,
    ST_FIN_WAIT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic seed_wr;
    logic push_rd;
    logic push_wr;
    logic div_start;
    logic div_report;
    logic take_quot;
    logic lv_dec;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic seed_mode;
    logic lv_zero;
    logic wrap;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- sv/cma_if.sv -----
// cascaded moving average: input and result channel interfaces
// valid/ready handshake with payload; uses cma_pkg for widths
`default_nettype none

interface cma_in_if import cma_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output mode, output sample, input ready);
  modport sink (input valid, input mode, input sample, output ready);
endinterface

interface cma_out_if import cma_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] average;
  logic                       level_advanced;

  modport source (output valid, output average, output level_advanced, input ready);
  modport sink (input valid, input average, input level_advanced, output ready);
endinterface

`default_nettype wire

// ----- sv/cma_div.sv -----
// cascaded moving average: signed-by-unsigned restoring divider, one bit per cycle
// truncates toward zero, zero divisor gives zero; uses cma_pkg
`default_nettype none

module cma_div import cma_pkg::*; #(
  parameter int TOTAL_W = 20,
  parameter int FILL_W  = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic signed [TOTAL_W-1:0]  dividend,
  input  wire logic        [FILL_W-1:0]   divisor,
  output      logic                       done,
  output      logic signed [SAMPLE_W-1:0] quot
);

  localparam int CNT_W = $clog2(TOTAL_W + 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [FILL_W:0]    rem;
  logic [TOTAL_W-1:0] quo;
  logic [FILL_W-1:0]  dvs;
  logic               neg;
  logic [FILL_W:0]    rem_sh;
  logic               fits;
  logic [SAMPLE_W-1:0] mag;

  assign rem_sh = {rem[FILL_W-1:0], quo[TOTAL_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(TOTAL_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[TOTAL_W-1];
      quo <= dividend[TOTAL_W-1] ? TOTAL_W'(-dividend) : TOTAL_W'(dividend);
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? (rem_sh - {1'b0, dvs}) : rem_sh;
      quo <= {quo[TOTAL_W-2:0], fits};
    end
  end

  assign mag  = quo[SAMPLE_W-1:0];
  assign quot = (dvs == '0) ? '0 : (neg ? -$signed(mag) : $signed(mag));

endmodule

`default_nettype wire

// ----- sv/cma_ctrl.sv -----
// cascaded moving average: sequencing state machine
// steps seed writes, window pushes and divisions; uses cma_pkg
`default_nettype none

module cma_ctrl import cma_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire sts_t sts,
  output      cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) state_next = ST_START;
      end
      ST_START: begin
        state_next = (sts.seed_mode == MODE_SEED) ? ST_SEED : ST_READ;
      end
      ST_SEED: begin
        cmd.seed_wr = 1'b1;
        if (sts.lv_zero) begin
          state_next = ST_FIN;
        end else begin
          cmd.lv_dec = 1'b1;
        end
      end
      ST_READ: begin
        cmd.push_rd = 1'b1;
        state_next  = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.push_wr = 1'b1;
        // carry into the slower level only when slot zero was just written
        if (!sts.lv_zero && sts.wrap) state_next = ST_DIV;
        else state_next = ST_FIN;
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.take_quot = 1'b1;
          cmd.lv_dec    = 1'b1;
          state_next    = ST_READ;
        end
      end
      ST_FIN: begin
        cmd.div_start  = 1'b1;
        cmd.div_report = 1'b1;
        state_next     = ST_FIN_WAIT;
      end
      ST_FIN_WAIT: begin
        cmd.div_report = 1'b1;
        if (sts.div_done && sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/cma_dp.sv -----
// cascaded moving average: datapath with window memory, level totals and divider
// driven by cma_ctrl commands; uses cma_pkg, cma_if and cma_div
`default_nettype none

module cma_dp import cma_pkg::*; #(
  parameter int WINDOW_POINTS = WINDOW_POINTS_DEF,
  parameter int LEVELS        = LEVELS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  cma_in_if.sink                   item,
  cma_out_if.source                result,
  input  wire logic                cfg_we,
  input  wire logic [REPORT_W-1:0] cfg_data,
  input  wire cmd_t                cmd,
  output      sts_t                sts
);

  localparam int FILL_W  = $clog2(WINDOW_POINTS + 1);
  localparam int POS_W   = $clog2(WINDOW_POINTS);
  localparam int LV_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int TOTAL_W = SAMPLE_W + FILL_W;
  localparam int DEPTH   = LEVELS * WINDOW_POINTS;
  localparam int ADDR_W  = $clog2(DEPTH);

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data;

  logic signed [TOTAL_W-1:0] totals [LEVELS];
  logic        [FILL_W-1:0]  fill   [LEVELS];
  logic        [POS_W-1:0]   wpos   [LEVELS];
  logic        [LEVELS-1:0]  took;

  logic                       mode;
  logic signed [SAMPLE_W-1:0] push_data;
  logic        [LV_W-1:0]     lv;
  logic        [REPORT_W-1:0] report_level;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_avg;
  logic                       out_adv;

  logic                       accept;
  logic        [LV_W-1:0]     rl;
  logic        [LV_W-1:0]     div_lv;
  logic        [POS_W-1:0]    addr_pos;
  logic        [ADDR_W-1:0]   addr;
  logic        [FILL_W-1:0]   pos_inc;
  logic                       full;
  logic signed [TOTAL_W-1:0]  total_next;
  logic                       div_done;
  logic signed [SAMPLE_W-1:0] div_q;

  assign accept     = item.valid && item.ready;
  assign item.ready = cmd.in_ready && !rst;

  assign rl = (int'(report_level) > LEVELS - 1) ? LV_W'(LEVELS - 1) : LV_W'(report_level);
  assign div_lv = cmd.div_report ? rl : lv;

  assign addr_pos = cmd.seed_wr ? '0 : wpos[lv];
  assign addr     = ADDR_W'(int'(lv) * WINDOW_POINTS + int'(addr_pos));

  assign pos_inc = FILL_W'(wpos[lv]) + FILL_W'(1);
  assign full    = fill[lv] >= FILL_W'(WINDOW_POINTS);
  // drop the overwritten sample once the window is full
  assign total_next = totals[lv]
                    - (full ? TOTAL_W'(rd_data) : TOTAL_W'(0))
                    + TOTAL_W'(push_data);

  always_ff @(posedge clk) begin
    if (cmd.seed_wr || cmd.push_wr) mem[addr] <= push_data;
    if (cmd.push_rd) rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        totals[i] <= '0;
        fill[i]   <= '0;
        wpos[i]   <= '0;
      end
      took <= '0;
      lv   <= '0;
    end else begin
      if (accept) begin
        took <= '0;
        lv   <= LV_W'(LEVELS - 1);
      end else if (cmd.lv_dec) begin
        lv <= lv - 1'b1;
      end
      if (cmd.seed_wr) begin
        totals[lv] <= TOTAL_W'(push_data);
        fill[lv]   <= FILL_W'(1);
        wpos[lv]   <= POS_W'(1);
        took[lv]   <= 1'b1;
      end else if (cmd.push_wr) begin
        totals[lv] <= total_next;
        if (pos_inc > fill[lv]) fill[lv] <= pos_inc;
        wpos[lv] <= (pos_inc == FILL_W'(WINDOW_POINTS)) ? '0 : POS_W'(pos_inc);
        took[lv] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode      <= item.mode;
      push_data <= item.sample;
    end else if (cmd.take_quot) begin
      push_data <= div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report_level <= '0;
    end else if (cfg_we) begin
      report_level <= cfg_data;
    end
  end

  cma_div #(
    .TOTAL_W (TOTAL_W),
    .FILL_W  (FILL_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (totals[div_lv]),
    .divisor  (fill[div_lv]),
    .done     (div_done),
    .quot     (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_avg <= div_q;
      out_adv <= took[rl];
    end
  end

  assign result.valid          = out_valid;
  assign result.average        = out_avg;
  assign result.level_advanced = out_adv;

  always_comb begin
    sts.in_valid  = item.valid;
    sts.seed_mode = mode;
    sts.lv_zero   = (lv == '0);
    sts.wrap      = (wpos[lv] == '0);
    sts.div_done  = div_done;
    sts.out_free  = !out_valid || result.ready;
  end

endmodule

`default_nettype wire

// ----- sv/cascaded_moving_average_core.sv -----
// Cascaded moving average: LEVELS boxcar averagers of WINDOW_POINTS samples each.
// An update transaction pushes the sample into the fastest level; each time a level
// writes its slot zero, its truncated average is pushed into the next slower level.
// A seed transaction clears every level and loads the sample into each. The result
// gives the average of the level selected by report_level (0 is the slowest level;
// larger values saturate to the fastest) and whether that level took a sample.
// One transaction is worked on at a time; the one-bit-per-cycle divider sets the pace.
// The dividend is 16 + clog2(WINDOW_POINTS + 1) bits wide. An update runs one division
// for every level the carry ripples into and one for the result; a seed writes every
// level, then runs one division for the result. The next transaction is taken while
// a result waits.
// Depends on cma_pkg, cma_if, cma_ctrl, cma_dp and cma_div.
`default_nettype none

module cascaded_moving_average_core import cma_pkg::*; #(
  parameter int WINDOW_POINTS = WINDOW_POINTS_DEF,
  parameter int LEVELS        = LEVELS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  cma_in_if.sink                   item,
  cma_out_if.source                result,
  input  wire logic                cfg_we,
  input  wire logic [REPORT_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  cma_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  cma_dp #(
    .WINDOW_POINTS (WINDOW_POINTS),
    .LEVELS        (LEVELS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

`default_nettype wire
